FILE: hw/rtl/bfca_pkg.sv
// Shared constants and types of the best-fit chunk allocator.
// Used by bfca_cell, bfca_chain and best_fit_chunk_allocator_core.
package bfca_pkg;

  localparam int MAX_CHUNKS_DEF = 64;
  localparam int ADDR_BITS_DEF  = 32;

  // pool size after reset
  localparam logic [31:0] RESET_POOL_SIZE = 32'd1048576;

  // request opcodes
  localparam logic OPC_ALLOC = 1'b0;
  localparam logic OPC_FREE  = 1'b1;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OOM      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_DOUBLE   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // chain commands
  localparam logic [2:0] CMD_HOLD   = 3'd0;
  localparam logic [2:0] CMD_ROT    = 3'd1;
  localparam logic [2:0] CMD_WRITE  = 3'd2;
  localparam logic [2:0] CMD_INSERT = 3'd3;
  localparam logic [2:0] CMD_DELETE = 3'd4;
  localparam logic [2:0] CMD_INIT   = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic       free;
  } cell_cmd_t;

endpackage

FILE: hw/rtl/best_fit_chunk_allocator_core.sv
// Best-fit chunk allocator with coalescing: top level and request sequencer.
// Depends on bfca_pkg and bfca_chain.
//
// Usage: the input channel (in_valid/in_stall) carries one request word:
// opcode (0 allocate, 1 free), alloc_size and free_offset. The output channel
// (out_valid/out_stall) returns one result word per request: status,
// chunk_offset, chunk_size, free_bytes and free_chunk_count.
// The chunk table lives in a row of MAX_CHUNKS cells. A request rotates the
// whole row once past the head cell to find the best fit or the chunk to free
// and its neighbors, decides in S_DECIDE and, unless it returns an error
// status, writes the entry in S_WR, then inserts a split remainder (S_INS) or
// deletes up to two merged neighbors (S_DEL). One request is in work at a
// time: the next is taken only after the current one has passed S_DONE.
// The cfg channel (cfg_valid/cfg_ready) writes pool_size; it is ready whenever
// no request is in work, and the write restarts the pool as one free chunk.
// Reset gives a 1 MiB pool held as one free chunk. A stalled result holds in
// the output register; the block may take the next request meanwhile and
// finishes it once the pending result is taken.
module best_fit_chunk_allocator_core
  import bfca_pkg::*;
#(
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [31:0] alloc_size,
  input  logic [31:0] free_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] chunk_offset,
  output logic [31:0] chunk_size,
  output logic [31:0] free_bytes,
  output logic [6:0]  free_chunk_count
);

  localparam int AW = ADDR_BITS;
  localparam int IW = $clog2(MAX_CHUNKS);
  localparam int UW = $clog2(MAX_CHUNKS + 1);
  localparam int CW = (AW > 32) ? AW : 32;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_CHUNKS - 1);
  localparam logic [UW-1:0] FULL_CNT = UW'(MAX_CHUNKS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_WR     = 3'd3;
  localparam logic [2:0] S_INS    = 3'd4;
  localparam logic [2:0] S_DEL    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state;
  logic [IW-1:0] scan_cnt;

  // request word
  logic        op;
  logic [31:0] req;
  logic [31:0] where;

  // pool bookkeeping
  logic [AW-1:0] fb;
  logic [UW-1:0] fc;
  logic [UW-1:0] used;
  logic [31:0]   stamp_cnt;

  // best-fit search
  logic          b_found;
  logic [IW-1:0] b_idx;
  logic [AW-1:0] b_size, b_off;
  logic [31:0]   b_stamp;

  // free search and neighbors
  logic          f_found, f_free, grab;
  logic [IW-1:0] f_idx;
  logic [AW-1:0] f_size, f_off;
  logic          p_free;
  logic [AW-1:0] p_size, p_off;
  logic          l_free, r_free;
  logic [AW-1:0] l_size, l_off, r_size;

  // update sequence
  logic [IW-1:0] w_idx, del_idx;
  logic [1:0]    ndel;
  logic          ins_pend;
  logic [AW-1:0] ins_off, ins_rem;
  logic [AW-1:0] d_off, d_size;
  logic          d_free;
  logic [31:0]   d_stamp;

  // result
  logic [2:0]    res_st;
  logic [AW-1:0] res_off, res_size;

  // chain interface
  cell_cmd_t     cmd;
  logic [IW-1:0] cmd_idx;
  logic [AW-1:0] cmd_size;
  logic [AW-1:0] h_off, h_size;
  logic          h_free, h_valid;
  logic [31:0]   h_stamp;

  logic cfg_we, in_take, out_take;
  logic fit, better, match;
  logic [AW-1:0] rem, merged, req_a;

  assign cfg_ready = (state == S_IDLE);
  assign cfg_we    = cfg_valid & cfg_ready;
  assign in_stall  = (state != S_IDLE) | cfg_valid;
  assign in_take   = in_valid & ~in_stall;
  assign out_take  = out_valid & ~out_stall;

  // head cell tests during the scan
  assign fit    = h_valid & h_free & (CW'(h_size) >= CW'(req));
  assign better = ~b_found | (h_size < b_size) | ((h_size == b_size) & (h_stamp < b_stamp));
  assign match  = h_valid & ~f_found & (CW'(h_off) == CW'(where));

  assign req_a  = AW'(req);
  assign rem    = b_size - req_a;
  assign merged = (l_free ? l_size : '0) + f_size + (r_free ? r_size : '0);

  // command to the chain
  always_comb begin
    cmd.op   = CMD_HOLD;
    cmd.free = d_free;
    cmd_idx  = w_idx;
    cmd_size = d_size;
    case (state)
      S_IDLE: begin
        if (cfg_we) begin
          cmd.op   = CMD_INIT;
          cmd_size = AW'(cfg_data);
        end
      end
      S_SCAN: cmd.op = CMD_ROT;
      S_WR:   cmd.op = CMD_WRITE;
      S_INS: begin
        cmd.op  = CMD_INSERT;
        cmd_idx = w_idx + IW'(1);
      end
      S_DEL: begin
        cmd.op  = CMD_DELETE;
        cmd_idx = del_idx;
      end
      default: ;
    endcase
  end

  bfca_chain #(.MAX_CHUNKS(MAX_CHUNKS), .AW(AW), .IW(IW)) u_chain (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .cmd_idx (cmd_idx),
    .d_off   (d_off),
    .d_size  (cmd_size),
    .d_stamp (d_stamp),
    .h_off   (h_off),
    .h_size  (h_size),
    .h_free  (h_free),
    .h_valid (h_valid),
    .h_stamp (h_stamp)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      fb        <= AW'(RESET_POOL_SIZE);
      fc        <= UW'(1);
      used      <= UW'(1);
      stamp_cnt <= 32'd1;
      scan_cnt  <= '0;
      ndel      <= '0;
      ins_pend  <= 1'b0;
    end else begin
      if (out_take && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_we) begin
            fb        <= AW'(cfg_data);
            fc        <= UW'(1);
            used      <= UW'(1);
            stamp_cnt <= 32'd1;
          end else if (in_take) begin
            scan_cnt <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + IW'(1);
          if (scan_cnt == LAST_IDX) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (op == OPC_ALLOC && req != 32'd0 && b_found &&
              !(rem != '0 && used == FULL_CNT)) begin
            fb       <= fb - req_a;
            ins_pend <= (rem != '0);
            ndel     <= '0;
            if (rem == '0) begin
              fc <= fc - UW'(1);
            end
            state <= S_WR;
          end else if (op == OPC_FREE && f_found && !f_free) begin
            fb        <= fb + f_size;
            fc        <= fc + UW'(1) - UW'(l_free) - UW'(r_free);
            used      <= used - UW'(l_free) - UW'(r_free);
            ndel      <= 2'(l_free) + 2'(r_free);
            ins_pend  <= 1'b0;
            stamp_cnt <= stamp_cnt + 32'd1;
            state     <= S_WR;
          end else begin
            ins_pend <= 1'b0;
            ndel     <= '0;
            state    <= S_DONE;
          end
        end
        S_WR: begin
          if (ins_pend) begin
            stamp_cnt <= stamp_cnt + 32'd1;
            used      <= used + UW'(1);
            state     <= S_INS;
          end else if (ndel != '0) begin
            state <= S_DEL;
          end else begin
            state <= S_DONE;
          end
        end
        S_INS: state <= S_DONE;
        S_DEL: begin
          ndel <= ndel - 2'd1;
          if (ndel == 2'd1) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // search flags
  always_ff @(posedge clk) begin
    if (rst) begin
      b_found <= 1'b0;
      f_found <= 1'b0;
      grab    <= 1'b0;
      l_free  <= 1'b0;
      r_free  <= 1'b0;
    end else if (in_take) begin
      b_found <= 1'b0;
      f_found <= 1'b0;
      grab    <= 1'b0;
      l_free  <= 1'b0;
      r_free  <= 1'b0;
    end else if (state == S_SCAN) begin
      if (op == OPC_ALLOC && fit && better) begin
        b_found <= 1'b1;
      end
      grab <= match;
      if (match) begin
        f_found <= 1'b1;
        l_free  <= (scan_cnt != '0) & p_free;
      end
      if (grab) begin
        r_free <= h_valid & h_free;
      end
    end
  end

  // search payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      op    <= opcode;
      req   <= alloc_size;
      where <= free_offset;
    end
    if (state == S_SCAN) begin
      p_free <= h_valid & h_free;
      p_size <= h_size;
      p_off  <= h_off;
      if (op == OPC_ALLOC && fit && better) begin
        b_idx   <= scan_cnt;
        b_size  <= h_size;
        b_off   <= h_off;
        b_stamp <= h_stamp;
      end
      if (match) begin
        f_idx  <= scan_cnt;
        f_free <= h_free;
        f_size <= h_size;
        f_off  <= h_off;
        l_size <= p_size;
        l_off  <= p_off;
      end
      if (grab) begin
        r_size <= h_size;
      end
    end
  end

  // update data and result
  always_ff @(posedge clk) begin
    case (state)
      S_DECIDE: begin
        if (op == OPC_ALLOC) begin
          if (req == 32'd0 || !b_found) begin
            res_st   <= ST_OOM;
            res_off  <= '0;
            res_size <= '0;
          end else if (rem != '0 && used == FULL_CNT) begin
            res_st   <= ST_FULL;
            res_off  <= '0;
            res_size <= '0;
          end else begin
            res_st   <= ST_OK;
            res_off  <= b_off;
            res_size <= req_a;
            w_idx    <= b_idx;
            d_off    <= b_off;
            d_size   <= req_a;
            d_free   <= 1'b0;
            d_stamp  <= '0;
            ins_off  <= b_off + req_a;
            ins_rem  <= rem;
          end
        end else if (!f_found) begin
          res_st   <= ST_NOTFOUND;
          res_off  <= '0;
          res_size <= '0;
        end else if (f_free) begin
          res_st   <= ST_DOUBLE;
          res_off  <= '0;
          res_size <= '0;
        end else begin
          res_st   <= ST_OK;
          res_off  <= l_free ? l_off : f_off;
          res_size <= merged;
          w_idx    <= l_free ? f_idx - IW'(1) : f_idx;
          del_idx  <= l_free ? f_idx : f_idx + IW'(1);
          d_off    <= l_free ? l_off : f_off;
          d_size   <= merged;
          d_free   <= 1'b1;
          d_stamp  <= stamp_cnt;
        end
      end
      S_WR: begin
        // remainder entry of a split takes a fresh stamp
        d_off   <= ins_off;
        d_size  <= ins_rem;
        d_free  <= 1'b1;
        d_stamp <= stamp_cnt;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          status           <= res_st;
          chunk_offset     <= 32'(res_off);
          chunk_size       <= 32'(res_size);
          free_bytes       <= 32'(fb);
          free_chunk_count <= 7'(fc);
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/bfca_cell.sv
// One chunk table entry of the allocator chain.
// Depends on bfca_pkg for the command codes and reset pool size.
module bfca_cell
  import bfca_pkg::*;
#(
  parameter int IDX = 0,
  parameter int AW  = ADDR_BITS_DEF,
  parameter int IW  = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_cmd_t     cmd,
  input  logic [IW-1:0] cmd_idx,
  input  logic [AW-1:0] d_off,
  input  logic [AW-1:0] d_size,
  input  logic [31:0]   d_stamp,
  input  logic [AW-1:0] l_off,
  input  logic [AW-1:0] l_size,
  input  logic          l_free,
  input  logic          l_valid,
  input  logic [31:0]   l_stamp,
  input  logic [AW-1:0] r_off,
  input  logic [AW-1:0] r_size,
  input  logic          r_free,
  input  logic          r_valid,
  input  logic [31:0]   r_stamp,
  output logic [AW-1:0] q_off,
  output logic [AW-1:0] q_size,
  output logic          q_free,
  output logic          q_valid,
  output logic [31:0]   q_stamp
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic          IS_HEAD = (IDX == 0);

  logic take_left, take_right, take_data;

  // select where this entry's next value comes from
  always_comb begin
    take_left  = 1'b0;
    take_right = 1'b0;
    take_data  = 1'b0;
    case (cmd.op)
      CMD_ROT:    take_right = 1'b1;
      CMD_WRITE:  take_data  = (cmd_idx == MY_IDX);
      CMD_INSERT: begin
        take_left = (MY_IDX > cmd_idx);
        take_data = (MY_IDX == cmd_idx);
      end
      CMD_DELETE: take_right = (MY_IDX >= cmd_idx);
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.op == CMD_INIT) begin
      q_off   <= '0;
      q_stamp <= '0;
      q_free  <= IS_HEAD;
      q_valid <= IS_HEAD;
      if (IS_HEAD) begin
        q_size <= rst ? AW'(RESET_POOL_SIZE) : d_size;
      end else begin
        q_size <= '0;
      end
    end else if (take_data) begin
      q_off   <= d_off;
      q_size  <= d_size;
      q_free  <= cmd.free;
      q_valid <= 1'b1;
      q_stamp <= d_stamp;
    end else if (take_left) begin
      q_off   <= l_off;
      q_size  <= l_size;
      q_free  <= l_free;
      q_valid <= l_valid;
      q_stamp <= l_stamp;
    end else if (take_right) begin
      q_off   <= r_off;
      q_size  <= r_size;
      q_free  <= r_free;
      q_valid <= r_valid;
      q_stamp <= r_stamp;
    end
  end

endmodule

FILE: hw/rtl/bfca_chain.sv
// Row of chunk cells, kept in offset order, with rotate, insert and delete.
// Depends on bfca_pkg and bfca_cell.
module bfca_chain
  import bfca_pkg::*;
#(
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF,
  parameter int AW         = ADDR_BITS_DEF,
  parameter int IW         = $clog2(MAX_CHUNKS)
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_cmd_t     cmd,
  input  logic [IW-1:0] cmd_idx,
  input  logic [AW-1:0] d_off,
  input  logic [AW-1:0] d_size,
  input  logic [31:0]   d_stamp,
  output logic [AW-1:0] h_off,
  output logic [AW-1:0] h_size,
  output logic          h_free,
  output logic          h_valid,
  output logic [31:0]   h_stamp
);

  logic [AW-1:0] c_off   [MAX_CHUNKS];
  logic [AW-1:0] c_size  [MAX_CHUNKS];
  logic          c_free  [MAX_CHUNKS];
  logic          c_valid [MAX_CHUNKS];
  logic [31:0]   c_stamp [MAX_CHUNKS];

  // the tail wraps to the head only while rotating; a delete shifts in an empty entry
  logic tail_wrap;
  assign tail_wrap = (cmd.op == CMD_ROT);

  for (genvar i = 0; i < MAX_CHUNKS; i++) begin : g_cell
    logic [AW-1:0] lo, ls, ro, rs;
    logic          lf, lv, rf, rv;
    logic [31:0]   lt, rt;

    if (i == 0) begin : g_left_edge
      assign lo = '0;
      assign ls = '0;
      assign lf = 1'b0;
      assign lv = 1'b0;
      assign lt = '0;
    end else begin : g_left
      assign lo = c_off[i-1];
      assign ls = c_size[i-1];
      assign lf = c_free[i-1];
      assign lv = c_valid[i-1];
      assign lt = c_stamp[i-1];
    end

    if (i == MAX_CHUNKS - 1) begin : g_right_edge
      assign ro = tail_wrap ? c_off[0]   : '0;
      assign rs = tail_wrap ? c_size[0]  : '0;
      assign rf = tail_wrap & c_free[0];
      assign rv = tail_wrap & c_valid[0];
      assign rt = tail_wrap ? c_stamp[0] : '0;
    end else begin : g_right
      assign ro = c_off[i+1];
      assign rs = c_size[i+1];
      assign rf = c_free[i+1];
      assign rv = c_valid[i+1];
      assign rt = c_stamp[i+1];
    end

    bfca_cell #(.IDX(i), .AW(AW), .IW(IW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .cmd_idx (cmd_idx),
      .d_off   (d_off),
      .d_size  (d_size),
      .d_stamp (d_stamp),
      .l_off   (lo),
      .l_size  (ls),
      .l_free  (lf),
      .l_valid (lv),
      .l_stamp (lt),
      .r_off   (ro),
      .r_size  (rs),
      .r_free  (rf),
      .r_valid (rv),
      .r_stamp (rt),
      .q_off   (c_off[i]),
      .q_size  (c_size[i]),
      .q_free  (c_free[i]),
      .q_valid (c_valid[i]),
      .q_stamp (c_stamp[i])
    );
  end

  assign h_off   = c_off[0];
  assign h_size  = c_size[0];
  assign h_free  = c_free[0];
  assign h_valid = c_valid[0];
  assign h_stamp = c_stamp[0];

endmodule
